### design/nsff_pkg.sv
// nsff_pkg: constants, state encoding and control structs of the NMEA sentence framer
// used by nsff_ctrl, nsff_dp and nmea_sentence_framer_filter; no dependencies
package nsff_pkg;

  // line store sizing
  localparam int LINE_CAPACITY = 64;
  localparam int ADDR_W        = $clog2(LINE_CAPACITY);
  localparam int CNT_W         = 32;

  // characters
  localparam logic [7:0] CH_START   = 8'h24;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;

  // line qualification
  localparam int MIN_VALID_LEN = 7;
  localparam int TYPE_MIN_IDX  = 4;
  localparam int PREFIX_LEN    = 9;
  localparam int PREFIX_IDX_W  = $clog2(PREFIX_LEN);

  // proprietary sentence prefix, one character per position
  localparam logic [7:0] PREFIX_CHARS [PREFIX_LEN] = '{
    8'h24, 8'h50, 8'h51, 8'h54, 8'h4D, 8'h45, 8'h50, 8'h45, 8'h2C
  };

  // accepted sentence types, first character in the upper byte
  localparam logic [23:0] TYPE_RMC = 24'h524D43;
  localparam logic [23:0] TYPE_GGA = 24'h474741;
  localparam logic [23:0] TYPE_GNS = 24'h474E53;
  localparam logic [23:0] TYPE_VTG = 24'h565447;
  localparam logic [23:0] TYPE_GST = 24'h475354;

  function automatic logic is_known_type(input logic [23:0] three);
    return (three == TYPE_RMC) || (three == TYPE_GGA) || (three == TYPE_GNS) ||
           (three == TYPE_VTG) || (three == TYPE_GST);
  endfunction

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHOW
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;   // input transfer this cycle
    logic start;    // begin replay of the completed line
    logic advance;  // step to the next stored byte
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fwd_now;  // current input byte completes a line that is forwarded
    logic last;     // replay pointer sits on the final byte
  } dp_sts_t;

endpackage

### design/nsff_ctrl.sv
// nsff_ctrl: handshake controller of the NMEA sentence framer
// depends on nsff_pkg; drives nsff_dp through dp_cmd_t, reads dp_sts_t
module nsff_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  nsff_pkg::dp_sts_t sts,
  output nsff_pkg::dp_cmd_t cmd
);
  import nsff_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && sts.fwd_now) begin
          cmd.start  = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        // store read data is registered in this state
        state_next = S_SHOW;
      end
      S_SHOW: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.last) begin
            state_next = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_READ;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // input and output never open together
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output handshakes open at once");

  // a forwarded line always enters replay
  a_start_reads: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (state == S_READ))
    else $error("replay start did not fetch");

  // final byte transfer returns to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && sts.last) |=> (state == S_IDLE))
    else $error("replay did not end after final byte");

endmodule

### design/nsff_dp.sv
// nsff_dp: line collection, sentence matching, counters and line store of the framer
// depends on nsff_pkg; commanded by nsff_ctrl
module nsff_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [7:0]                      rx_byte,
  input  nsff_pkg::dp_cmd_t               cmd,
  output nsff_pkg::dp_sts_t               sts,
  output logic [7:0]                      out_byte,
  output logic                            out_last,
  output logic [nsff_pkg::CNT_W-1:0]      valid_lines,
  output logic [nsff_pkg::CNT_W-1:0]      forwarded_lines,
  output logic [nsff_pkg::CNT_W-1:0]      dropped_lines
);
  import nsff_pkg::*;

  // line collection state
  logic              collecting;
  logic [ADDR_W-1:0] fill;
  logic              comma_seen;
  logic              type_match;
  logic [23:0]       recent;
  logic              prefix_match;
  logic [CNT_W-1:0]  valid_count;
  logic [CNT_W-1:0]  forward_count;
  logic [CNT_W-1:0]  drop_count;

  // replay state
  logic [7:0]        mem [LINE_CAPACITY];
  logic [7:0]        rd_data;
  logic [ADDR_W-1:0] rd_ptr;
  logic [ADDR_W-1:0] replay_len;

  // per-byte evaluation
  logic              restart;
  logic              coll_a;
  logic [ADDR_W-1:0] idx;
  logic              comma_a;
  logic              type_a;
  logic [23:0]       recent_a;
  logic              prefix_a;
  logic              overflow;
  logic              store;
  logic              prefix_next;
  logic              comma_hit;
  logic              type_next;
  logic              newline;
  logic [ADDR_W-1:0] len;
  logic              valid_line;
  logic              fwd;

  // a start character restarts the line before the byte is stored
  always_comb begin
    restart     = (rx_byte == CH_START);
    coll_a      = collecting | restart;
    idx         = restart ? '0 : fill;
    comma_a     = restart ? 1'b0 : comma_seen;
    type_a      = restart ? 1'b0 : type_match;
    recent_a    = restart ? '0 : recent;
    prefix_a    = restart ? 1'b1 : prefix_match;
    overflow    = coll_a && (idx >= ADDR_W'(LINE_CAPACITY - 1));
    store       = coll_a && !overflow;
    prefix_next = prefix_a;
    if (idx < ADDR_W'(PREFIX_LEN)) begin
      if (rx_byte != PREFIX_CHARS[idx[PREFIX_IDX_W-1:0]]) begin
        prefix_next = 1'b0;
      end
    end
    comma_hit   = !comma_a && (rx_byte == CH_COMMA);
    type_next   = comma_hit ? ((idx >= ADDR_W'(TYPE_MIN_IDX)) && is_known_type(recent_a))
                            : type_a;
    newline     = store && (rx_byte == CH_NEWLINE);
    len         = idx + 1'b1;
    valid_line  = newline && (len >= ADDR_W'(MIN_VALID_LEN));
    fwd         = valid_line && (prefix_next || type_next);
  end

  // collection state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      collecting    <= 1'b0;
      fill          <= '0;
      comma_seen    <= 1'b0;
      type_match    <= 1'b0;
      recent        <= '0;
      prefix_match  <= 1'b1;
      valid_count   <= '0;
      forward_count <= '0;
      drop_count    <= '0;
    end else if (cmd.accept) begin
      if (overflow || newline) begin
        collecting   <= 1'b0;
        fill         <= '0;
        comma_seen   <= 1'b0;
        type_match   <= 1'b0;
        recent       <= '0;
        prefix_match <= 1'b1;
        if (overflow) begin
          drop_count <= drop_count + 1'b1;
        end
        if (valid_line) begin
          valid_count <= valid_count + 1'b1;
        end
        if (fwd) begin
          forward_count <= forward_count + 1'b1;
        end
      end else if (store) begin
        collecting   <= 1'b1;
        fill         <= len;
        comma_seen   <= comma_a | comma_hit;
        type_match   <= type_next;
        recent       <= {recent_a[15:0], rx_byte};
        prefix_match <= prefix_next;
      end
    end
  end

  // line store, write port
  always_ff @(posedge clk) begin
    if (cmd.accept && store) begin
      mem[idx] <= rx_byte;
    end
  end

  // line store, registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_ptr];
  end

  // replay pointer and length
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
    end else if (cmd.start) begin
      rd_ptr <= '0;
    end else if (cmd.advance) begin
      rd_ptr <= rd_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      replay_len <= len;
    end
  end

  assign sts.fwd_now     = fwd;
  assign sts.last        = (rd_ptr == replay_len - 1'b1);
  assign out_byte        = rd_data;
  assign out_last        = sts.last;
  assign valid_lines     = valid_count;
  assign forwarded_lines = forward_count;
  assign dropped_lines   = drop_count;

  // a replayed line always meets the minimum length
  a_len_min: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (replay_len >= ADDR_W'(MIN_VALID_LEN)))
    else $error("replay of a short line");

  // the pointer never steps past the final byte
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.advance |-> (rd_ptr < replay_len - 1'b1))
    else $error("replay pointer past line end");

  // a forwarded line bumps the forward counter
  a_fwd_count: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (forward_count == $past(forward_count) + 1'b1))
    else $error("forward counter missed a line");

endmodule

### design/nmea_sentence_framer_filter.sv
// nmea_sentence_framer_filter: top level of the NMEA sentence framer and filter
// depends on nsff_pkg, nsff_ctrl and nsff_dp
//
// Usage:
//   Input channel rx_byte/in_valid/in_ready takes one character of the receiver
//   text stream per transfer. A '$' starts a line; bytes outside a line are
//   dropped silently. A line that reaches 63 stored bytes without a newline is
//   abandoned and dropped_lines counts it.
//   On the newline of a line of at least 7 bytes whose sentence type is
//   accepted (or that carries the proprietary prefix), the stored line is
//   replayed on out_byte/out_valid/out_ready, out_last marking the newline.
//   The three counter ports go with every output byte and wrap at 2^32.
//   Outside a replay in_ready stays high, so every offered byte is accepted.
//   After a forwarding newline each stored byte is read from the store into a
//   register, then shown on out_byte until out_ready takes it. in_ready is
//   low for the whole replay, since the one line store holds the line under
//   replay until its last byte is out.
//   A stalled receiver holds the current byte in place; nothing is lost.
//   Reset (rst, synchronous) clears counters and collection state and returns
//   to accepting input in the next cycle; the store itself is not cleared.
module nmea_sentence_framer_filter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [7:0]                 rx_byte,
  input  logic                       in_valid,
  output logic                       in_ready,
  output logic [7:0]                 out_byte,
  output logic                       out_last,
  output logic [nsff_pkg::CNT_W-1:0] valid_lines,
  output logic [nsff_pkg::CNT_W-1:0] forwarded_lines,
  output logic [nsff_pkg::CNT_W-1:0] dropped_lines,
  output logic                       out_valid,
  input  logic                       out_ready
);
  import nsff_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // handshake controller
  nsff_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // collection, matching and replay datapath
  nsff_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .rx_byte         (rx_byte),
    .cmd             (cmd),
    .sts             (sts),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .valid_lines     (valid_lines),
    .forwarded_lines (forwarded_lines),
    .dropped_lines   (dropped_lines)
  );

endmodule
